// ===== hw/rtl/saa_pkg.sv =====
// Shared types and constants for the skyline atlas allocator.
package saa_pkg;

	localparam int unsigned ROW_W = 13;
	localparam int unsigned REQ_W_W = 11;
	localparam int unsigned POS_X_W = 10;
	localparam int unsigned POS_Y_W = 12;
	localparam logic [ROW_W-1:0] HEIGHT_LIMIT = 13'd4096;
	localparam logic [ROW_W-1:0] HEIGHT_RESET = 13'd1024;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SUFFIX,
		ST_PREFIX,
		ST_DECIDE,
		ST_WRITE
	} state_t;

	typedef struct packed {
		logic clear_run;
		logic load;
		logic suf_run;
		logic pre_run;
		logic emit;
		logic wr_run;
	} cmd_t;

	typedef struct packed {
		logic clr_done;
		logic bad;
		logic suf_done;
		logic pre_done;
		logic out_busy;
		logic fits;
		logic wr_done;
	} status_t;

endpackage

// ===== hw/rtl/saa_ctrl.sv =====
// Sequencing state machine of the skyline atlas allocator.
module saa_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  saa_pkg::status_t st,
	output saa_pkg::cmd_t   cmd
);
	import saa_pkg::*;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (st.clr_done) state_nxt = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) state_nxt = ST_SUFFIX;
			end
			ST_SUFFIX: begin
				// A malformed request skips both scans and reports full.
				if (st.bad) state_nxt = ST_DECIDE;
				else if (st.suf_done) state_nxt = ST_PREFIX;
			end
			ST_PREFIX: begin
				if (st.pre_done) state_nxt = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (!st.out_busy) state_nxt = st.fits ? ST_WRITE : ST_IDLE;
			end
			ST_WRITE: begin
				if (st.wr_done) state_nxt = ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear_run = 1'b1;
			end
			ST_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			ST_SUFFIX: begin
				cmd.suf_run = !st.bad;
			end
			ST_PREFIX: begin
				cmd.pre_run = 1'b1;
			end
			ST_DECIDE: begin
				cmd.emit = !st.out_busy;
			end
			ST_WRITE: begin
				cmd.wr_run = 1'b1;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	a_accept_starts_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && in_valid) |=> state_q == ST_SUFFIX)
		else $error("accepted word did not start the suffix scan");

	a_prefix_ends_in_decide: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.pre_run && st.pre_done) |=> state_q == ST_DECIDE)
		else $error("prefix scan end did not lead to the decision");

	a_write_only_when_fits: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && !st.fits) |=> state_q == ST_IDLE)
		else $error("rejected request went on to update the skyline");

endmodule

// ===== hw/rtl/saa_datapath.sv =====
// Skyline storage, window scans and result register of the atlas allocator.
module saa_datapath #(
	parameter int unsigned ATLAS_WIDTH = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wen,
	input  logic [saa_pkg::ROW_W-1:0]     cfg_wdata,
	input  logic [saa_pkg::REQ_W_W-1:0]   req_width,
	input  logic [saa_pkg::ROW_W-1:0]     req_height,
	input  logic                          out_stall,
	output logic                          out_valid,
	output logic [saa_pkg::POS_X_W-1:0]   pos_x,
	output logic [saa_pkg::POS_Y_W-1:0]   pos_y,
	output logic                          full_res,
	input  saa_pkg::cmd_t                 cmd,
	output saa_pkg::status_t              st
);
	import saa_pkg::*;

	localparam int unsigned AW = $clog2(ATLAS_WIDTH);
	localparam int unsigned AW1 = AW + 1;
	localparam int unsigned WW = $clog2(ATLAS_WIDTH + 1);
	localparam logic [AW-1:0] LAST_COL = AW'(ATLAS_WIDTH - 1);

	logic [ROW_W-1:0] fill_mem [ATLAS_WIDTH];
	logic [ROW_W-1:0] sfx_mem [ATLAS_WIDTH];

	// Control registers.
	logic [ROW_W-1:0] height_q;
	logic [AW-1:0]    addr_q;
	logic             iss_q;
	logic             rd_vld_s1;
	logic             out_valid_q;

	// Payload registers.
	logic [AW-1:0]    addr_s1;
	logic [AW-1:0]    xaddr_s1;
	logic             win_s1;
	logic [ROW_W-1:0] fill_rd_s1;
	logic [ROW_W-1:0] sfx_rd_s1;
	logic [WW-1:0]    w_q;
	logic [ROW_W-1:0] h_q;
	logic [ROW_W-1:0] limit_q;
	logic             bad_q;
	logic [WW-1:0]    k_q;
	logic [ROW_W-1:0] sfx_run_q;
	logic [ROW_W-1:0] pfx_run_q;
	logic [ROW_W-1:0] best_q;
	logic [AW-1:0]    bestx_q;
	logic             found_q;
	logic [WW-1:0]    cnt_q;
	logic [POS_X_W-1:0] pos_x_q;
	logic [POS_Y_W-1:0] pos_y_q;
	logic             full_q;

	logic [ROW_W-1:0] limit_in;
	logic             bad_in;
	logic [WW-1:0]    w_last;
	logic [AW1-1:0]   j_next;
	logic             win_now;
	logic [AW-1:0]    xaddr_now;
	logic [ROW_W-1:0] sfx_val;
	logic [ROW_W-1:0] pfx_val;
	logic [ROW_W-1:0] win_max;
	logic [ROW_W:0]   top_sum;
	logic [ROW_W-1:0] new_top;
	logic             fits;
	logic             suf_last;
	logic             pre_last;

	assign limit_in = (height_q > HEIGHT_LIMIT) ? HEIGHT_LIMIT : height_q;
	assign bad_in = (req_width == '0) || (req_height == '0)
		|| (32'(req_width) > ATLAS_WIDTH);
	assign w_last = w_q - WW'(1);

	// A window ending at column j starts at j + 1 - width.
	assign j_next = {1'b0, addr_q} + AW1'(1);
	assign win_now = j_next >= AW1'(w_q);
	assign xaddr_now = win_now ? AW'(j_next - AW1'(w_q)) : '0;

	// Block maxima run from the right edge in blocks of the request width.
	assign sfx_val = (k_q == '0) ? fill_rd_s1
		: ((fill_rd_s1 > sfx_run_q) ? fill_rd_s1 : sfx_run_q);
	assign pfx_val = ((k_q == w_last) || (addr_s1 == '0)) ? fill_rd_s1
		: ((fill_rd_s1 > pfx_run_q) ? fill_rd_s1 : pfx_run_q);
	assign win_max = (sfx_rd_s1 > pfx_val) ? sfx_rd_s1 : pfx_val;

	assign top_sum = {1'b0, best_q} + {1'b0, h_q};
	assign new_top = top_sum[ROW_W-1:0];
	assign fits = found_q && !bad_q && (top_sum <= {1'b0, limit_q});

	assign suf_last = rd_vld_s1 && (addr_s1 == '0);
	assign pre_last = rd_vld_s1 && (addr_s1 == LAST_COL);

	always_comb begin
		st = '0;
		st.clr_done = (addr_q == LAST_COL);
		st.bad = bad_q;
		st.suf_done = suf_last;
		st.pre_done = pre_last;
		st.out_busy = out_valid_q && out_stall;
		st.fits = fits;
		st.wr_done = (cnt_q == WW'(1));
	end

	always_ff @(posedge clk) begin
		if (cmd.clear_run) begin
			fill_mem[addr_q] <= '0;
		end else if (cmd.wr_run) begin
			fill_mem[addr_q] <= new_top;
		end
		fill_rd_s1 <= fill_mem[addr_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.suf_run && rd_vld_s1) begin
			sfx_mem[addr_s1] <= sfx_val;
		end
		sfx_rd_s1 <= sfx_mem[xaddr_now];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			height_q <= HEIGHT_RESET;
			addr_q <= '0;
			iss_q <= 1'b0;
			rd_vld_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wen) begin
				height_q <= cfg_wdata;
			end
			rd_vld_s1 <= (cmd.suf_run || cmd.pre_run) && iss_q;
			if (cmd.load) begin
				addr_q <= LAST_COL;
				iss_q <= 1'b1;
			end else if (cmd.suf_run) begin
				if (suf_last) begin
					addr_q <= '0;
					iss_q <= 1'b1;
				end else if (iss_q) begin
					if (addr_q == '0) iss_q <= 1'b0;
					else addr_q <= addr_q - AW'(1);
				end
			end else if (cmd.pre_run) begin
				if (iss_q) begin
					if (addr_q == LAST_COL) iss_q <= 1'b0;
					else addr_q <= addr_q + AW'(1);
				end
			end else if (cmd.emit) begin
				addr_q <= bestx_q;
			end else if (cmd.wr_run || cmd.clear_run) begin
				addr_q <= addr_q + AW'(1);
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= addr_q;
		xaddr_s1 <= xaddr_now;
		win_s1 <= win_now;
		if (cmd.load) begin
			w_q <= WW'(req_width);
			h_q <= req_height;
			limit_q <= limit_in;
			best_q <= limit_in;
			bad_q <= bad_in;
			k_q <= '0;
			found_q <= 1'b0;
		end else if (cmd.suf_run && rd_vld_s1) begin
			sfx_run_q <= sfx_val;
			// The last step leaves k at the phase of column zero.
			if (!suf_last) begin
				k_q <= (k_q == w_last) ? '0 : k_q + WW'(1);
			end
		end else if (cmd.pre_run && rd_vld_s1) begin
			pfx_run_q <= pfx_val;
			k_q <= (k_q == '0) ? w_last : k_q - WW'(1);
			if (win_s1 && (win_max < best_q)) begin
				best_q <= win_max;
				bestx_q <= xaddr_s1;
				found_q <= 1'b1;
			end
		end
		if (cmd.emit) begin
			cnt_q <= w_q;
			pos_x_q <= fits ? POS_X_W'(bestx_q) : '0;
			pos_y_q <= fits ? best_q[POS_Y_W-1:0] : '0;
			full_q <= !fits;
		end else if (cmd.wr_run) begin
			cnt_q <= cnt_q - WW'(1);
		end
	end

	assign out_valid = out_valid_q;
	assign pos_x = pos_x_q;
	assign pos_y = pos_y_q;
	assign full_res = full_q;

	a_window_alignment: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.pre_run && rd_vld_s1 && win_s1)
		|-> ({1'b0, xaddr_s1} + AW1'(w_q) - AW1'(1)) == {1'b0, addr_s1})
		else $error("window start and end column disagree");

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_run |-> (fits && (32'(addr_q) < ATLAS_WIDTH)))
		else $error("skyline update outside a fitting window");

	a_emit_not_over_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall && !cmd.emit) |=> out_valid_q)
		else $error("pending result word was dropped");

endmodule

// ===== hw/rtl/skyline_atlas_allocator_core.sv =====
// Top level of the skyline atlas allocator: controller plus datapath.
//
// Input channel: in_valid/in_stall carry one request word (req_width, req_height).
// Output channel: out_valid/out_stall carry one result word (pos_x, pos_y,
// full_res) for every request, in request order.
// Configuration: cfg_wen writes cfg_wdata into the atlas height register; write
// it only while the block is idle. Heights above 4096 act as 4096.
// After reset the block clears its column heights, one column a cycle, so
// in_stall stays high until every column has been cleared.
// Each request makes two passes over the skyline memory (block suffix maxima
// from the right, then prefix maxima and window choice from the left), then a
// decision state and, when the request fits, a write state that raises the
// covered columns. Malformed requests (zero size, too wide) skip both passes
// and the write. The result sits in an output register, so a new request is
// taken while the receiver stalls; the next result waits in the decision state
// until the previous word has been taken.
module skyline_atlas_allocator_core #(
	parameter int unsigned ATLAS_WIDTH = 1024
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wen,
	input  logic [saa_pkg::ROW_W-1:0]   cfg_wdata,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [saa_pkg::REQ_W_W-1:0] req_width,
	input  logic [saa_pkg::ROW_W-1:0]   req_height,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [saa_pkg::POS_X_W-1:0] pos_x,
	output logic [saa_pkg::POS_Y_W-1:0] pos_y,
	output logic                        full_res
);
	import saa_pkg::*;

	cmd_t    cmd;
	status_t st;

	saa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.st       (st),
		.cmd      (cmd)
	);

	saa_datapath #(
		.ATLAS_WIDTH (ATLAS_WIDTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wen    (cfg_wen),
		.cfg_wdata  (cfg_wdata),
		.req_width  (req_width),
		.req_height (req_height),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.full_res   (full_res),
		.cmd        (cmd),
		.st         (st)
	);

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the skyline atlas allocator core.
module testbench;
	import saa_pkg::*;

	localparam int unsigned ATLAS_W = 1024;
	localparam int unsigned CYCLE_LIMIT = 8000000;
	localparam int unsigned SETTLE_CYCLES = 2 * ATLAS_W + 16;

	typedef struct packed {
		logic [REQ_W_W-1:0] width;
		logic [ROW_W-1:0]   height;
	} rect_req_t;

	typedef struct packed {
		logic [POS_X_W-1:0] x;
		logic [POS_Y_W-1:0] y;
		logic               full;
	} placement_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_wen = 1'b0;
	logic [ROW_W-1:0]   cfg_wdata = '0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [REQ_W_W-1:0] req_width = '0;
	logic [ROW_W-1:0]   req_height = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [POS_X_W-1:0] pos_x;
	logic [POS_Y_W-1:0] pos_y;
	logic               full_res;

	rect_req_t   pending_reqs[$];
	placement_t  rects_due[$];
	logic [ROW_W-1:0] skyline[ATLAS_W];
	logic [ROW_W-1:0] atlas_rows = HEIGHT_RESET;
	rect_req_t   next_req;
	rect_req_t   taken_req;
	placement_t  want;
	logic        in_taken = 1'b0;
	bit          idle_on = 1'b1;
	int unsigned send_gap = 0;
	int unsigned stall_left = 0;
	int unsigned cycles = 0;
	int unsigned errors = 0;

	skyline_atlas_allocator_core #(
		.ATLAS_WIDTH(ATLAS_W)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.req_width (req_width),
		.req_height(req_height),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.full_res  (full_res)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Places one rectangle on the skyline kept here and returns where it went.
	function automatic placement_t place_rect(input rect_req_t r);
		placement_t  res;
		int unsigned limit, best, best_x, top, x;
		int unsigned win[$];
		bit          found;
		res.x = '0;
		res.y = '0;
		res.full = 1'b1;
		limit = (atlas_rows > HEIGHT_LIMIT) ? HEIGHT_LIMIT : atlas_rows;
		best = limit;
		best_x = 0;
		found = 1'b0;
		if (r.width == 0 || r.height == 0 || r.width > ATLAS_W)
			return res;
		// Sliding window maximum: win holds column indexes of falling fill, so
		// its front is the highest column of the window ending at x. Only a
		// strictly lower window replaces the best one, so ties stay leftmost.
		for (x = 0; x < ATLAS_W; x++) begin
			while (win.size() != 0 && skyline[win[win.size() - 1]] <= skyline[x])
				void'(win.pop_back());
			win.insert(win.size(), x);
			if (win[0] + r.width <= x)
				void'(win.pop_front());
			if (x + 1 >= r.width) begin
				top = skyline[win[0]];
				if (top < best) begin
					best = top;
					best_x = x + 1 - r.width;
					found = 1'b1;
				end
			end
		end
		if (!found || best + r.height > limit)
			return res;
		for (x = best_x; x < best_x + r.width; x++)
			skyline[x] = ROW_W'(best + r.height);
		res.x = POS_X_W'(best_x);
		res.y = POS_Y_W'(best);
		res.full = 1'b0;
		return res;
	endfunction

	// Mostly narrow, short rectangles so the atlas fills slowly; a few wide or
	// tall ones, and some malformed words.
	function automatic rect_req_t draw_request();
		rect_req_t   r;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		r.width = REQ_W_W'($urandom_range(1, 48));
		r.height = ROW_W'($urandom_range(1, 96));
		if (pick < 3) begin
			r.width = '0;
		end else if (pick < 5) begin
			r.height = '0;
		end else if (pick < 8) begin
			r.width = REQ_W_W'($urandom_range(ATLAS_W + 1, 2047));
			r.height = ROW_W'($urandom_range(1, 8191));
		end else if (pick < 80) begin
		end else if (pick < 92) begin
			r.width = REQ_W_W'($urandom_range(49, 256));
			r.height = ROW_W'($urandom_range(1, 32));
		end else if (pick < 97) begin
			r.width = REQ_W_W'($urandom_range(257, ATLAS_W));
			r.height = ROW_W'($urandom_range(1, 8));
		end else begin
			r.width = REQ_W_W'($urandom_range(1, ATLAS_W));
			r.height = ROW_W'($urandom_range(97, 8191));
		end
		return r;
	endfunction

	task automatic queue_rect(input int unsigned w, input int unsigned h);
		rect_req_t r;
		r.width = REQ_W_W'(w);
		r.height = ROW_W'(h);
		pending_reqs.insert(pending_reqs.size(), r);
	endtask

	task automatic queue_random(input int unsigned count);
		repeat (count)
			pending_reqs.insert(pending_reqs.size(), draw_request());
	endtask

	task automatic set_rows(input logic [ROW_W-1:0] rows);
		@(negedge clk);
		cfg_wen <= 1'b1;
		cfg_wdata <= rows;
		@(negedge clk);
		cfg_wen <= 1'b0;
	endtask

	// The block may still be raising columns after its last word goes out.
	task automatic drain();
		while (pending_reqs.size() != 0 || in_valid || rects_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	always @(negedge clk) begin
		if (!in_valid || in_taken) begin
			if (send_gap != 0) begin
				send_gap <= send_gap - 1;
				in_valid <= 1'b0;
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				send_gap <= $urandom_range(0, 6);
				in_valid <= 1'b0;
			end else if (pending_reqs.size() != 0) begin
				next_req = pending_reqs.pop_front();
				in_valid <= 1'b1;
				req_width <= next_req.width;
				req_height <= next_req.height;
			end else begin
				in_valid <= 1'b0;
			end
		end
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else if (idle_on && $urandom_range(0, 9) == 0) begin
			stall_left <= $urandom_range(0, 6);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		in_taken <= arst_n && in_valid && !in_stall;
		if (arst_n) begin
			if (cfg_wen)
				atlas_rows = cfg_wdata;
			if (in_valid && !in_stall) begin
				taken_req.width = req_width;
				taken_req.height = req_height;
				rects_due.insert(rects_due.size(), place_rect(taken_req));
			end
			if (out_valid && !out_stall) begin
				if (rects_due.size() == 0) begin
					errors++;
					$display("%0t: word with none expected: x=%0d y=%0d full=%0b",
						$time, pos_x, pos_y, full_res);
				end else begin
					want = rects_due.pop_front();
					if (pos_x !== want.x) begin
						errors++;
						$display("%0t: pos_x expected %0d, got %0d", $time, want.x, pos_x);
					end
					if (pos_y !== want.y) begin
						errors++;
						$display("%0t: pos_y expected %0d, got %0d", $time, want.y, pos_y);
					end
					if (full_res !== want.full) begin
						errors++;
						$display("%0t: full_res expected %0b, got %0b", $time, want.full,
							full_res);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		for (int c = 0; c < ATLAS_W; c++)
			skyline[c] = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed words at the reset height. The second lands on the last
		// start column, and later ones hit an exact fit, one row too many,
		// a tie and a skyline with no window below the atlas height.
		queue_rect(1000, 3);
		queue_rect(24, 2);
		queue_rect(1024, 1);
		queue_rect(1, 1);
		queue_rect(0, 5);
		queue_rect(5, 0);
		queue_rect(0, 0);
		queue_rect(1025, 1);
		queue_rect(2047, 8191);
		queue_rect(1, 8191);
		queue_rect(3, 1016);
		queue_rect(2, 1020);
		queue_rect(1, 1021);
		queue_rect(4, 10);
		queue_rect(1024, 1);
		queue_rect(512, 100);
		queue_rect(1023, 1);
		queue_rect(1, 4096);
		queue_rect(1024, 4096);
		queue_rect(16, 1);
		queue_rect(17, 2);
		drain();

		// Heights below every existing fill: nothing fits.
		set_rows(13'd1);
		queue_random(15);
		drain();
		idle_on = 1'b0;
		set_rows(13'd0);
		queue_random(10);
		drain();

		// All register bits set; the allocator saturates at the height limit.
		idle_on = 1'b1;
		set_rows(13'h1FFF);
		queue_random(200);
		drain();

		// Lowered below many filled columns.
		set_rows(13'd1500);
		queue_random(90);
		drain();

		set_rows(HEIGHT_LIMIT);
		queue_random(200);
		drain();

		idle_on = 1'b0;
		set_rows(HEIGHT_RESET);
		queue_random(65);
		drain();

		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
